[src/sdiv_pkg.sv]
// ----------------------------------------------------------------------------
// Signed divider package
// The type shared by the stages of the signed restoring divider pipeline.
// ----------------------------------------------------------------------------
package sdiv_pkg;

  // Per-stage control that travels alongside the datapath of each item.
  typedef struct packed {
    logic valid;     // The stage holds an item.
    logic negate;    // Operand signs differ, so the quotient is negated.
    logic div_zero;  // The divisor is zero, so the quotient is forced to zero.
  } sdiv_ctrl_t;

endpackage

[src/sdiv_pre.sv]
// ----------------------------------------------------------------------------
// Signed divider operand stage
// Registers the operand magnitudes and the sign and zero-divisor flags.
// ----------------------------------------------------------------------------
module sdiv_pre #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            stall_o,
  input  logic signed [OPERAND_WIDTH-1:0] dividend_i,
  input  logic signed [OPERAND_WIDTH-1:0] divisor_i,
  output sdiv_pkg::sdiv_ctrl_t            ctrl_o,
  output logic [OPERAND_WIDTH-1:0]        rem_o,
  output logic [OPERAND_WIDTH-1:0]        den_o,
  input  logic                            stall_i
);
  import sdiv_pkg::*;

  sdiv_ctrl_t               ctrl_d, ctrl_q;
  logic [OPERAND_WIDTH-1:0] dividend_u, divisor_u;
  logic [OPERAND_WIDTH-1:0] rem_d, rem_q;
  logic [OPERAND_WIDTH-1:0] den_d, den_q;
  logic                     load;

  assign stall_o = ctrl_q.valid & stall_i;
  assign load    = ~stall_o;

  assign dividend_u = dividend_i;
  assign divisor_u  = divisor_i;

  // The magnitude of the most negative value fits as an unsigned number.
  always_comb begin
    rem_d           = dividend_u[OPERAND_WIDTH-1] ? (~dividend_u + 1'b1) : dividend_u;
    den_d           = divisor_u[OPERAND_WIDTH-1] ? (~divisor_u + 1'b1) : divisor_u;
    ctrl_d.valid    = valid_i;
    ctrl_d.negate   = dividend_u[OPERAND_WIDTH-1] ^ divisor_u[OPERAND_WIDTH-1];
    ctrl_d.div_zero = (divisor_u == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (load) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q <= rem_d;
      den_q <= den_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign den_o  = den_q;

endmodule

[src/sdiv_step.sv]
// ----------------------------------------------------------------------------
// Signed divider restoring step
// One compare-and-subtract step that yields one quotient bit, registered.
// ----------------------------------------------------------------------------
module sdiv_step #(
  parameter int unsigned OPERAND_WIDTH = 16,
  parameter int unsigned SHIFT         = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sdiv_pkg::sdiv_ctrl_t     ctrl_i,
  output logic                     stall_o,
  input  logic [OPERAND_WIDTH-1:0] rem_i,
  input  logic [OPERAND_WIDTH-1:0] den_i,
  input  logic [OPERAND_WIDTH:0]   quo_i,
  output sdiv_pkg::sdiv_ctrl_t     ctrl_o,
  output logic [OPERAND_WIDTH-1:0] rem_o,
  output logic [OPERAND_WIDTH-1:0] den_o,
  output logic [OPERAND_WIDTH:0]   quo_o,
  input  logic                     stall_i
);
  import sdiv_pkg::*;

  sdiv_ctrl_t               ctrl_q;
  logic [OPERAND_WIDTH-1:0] rem_hi, den_sh;
  logic [OPERAND_WIDTH-1:0] rem_d, rem_q;
  logic [OPERAND_WIDTH-1:0] den_q;
  logic [OPERAND_WIDTH:0]   quo_d, quo_q;
  logic                     take;
  logic                     load;

  assign stall_o = ctrl_q.valid & stall_i;
  assign load    = ~stall_o;

  // When the step subtracts, the shifted divisor is no larger than the
  // remainder, so dropping its upper bits loses nothing.
  always_comb begin
    rem_hi = rem_i >> SHIFT;
    den_sh = den_i << SHIFT;
    take   = ~ctrl_i.div_zero & (rem_hi >= den_i);
    rem_d  = take ? (rem_i - den_sh) : rem_i;
    quo_d  = {quo_i[OPERAND_WIDTH-1:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (load) begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q <= rem_d;
      den_q <= den_i;
      quo_q <= quo_d;
    end
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign quo_o  = quo_q;

endmodule

[src/sdiv_post.sv]
// ----------------------------------------------------------------------------
// Signed divider sign stage
// Applies the quotient sign and holds the result for the output transfer.
// ----------------------------------------------------------------------------
module sdiv_post #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sdiv_pkg::sdiv_ctrl_t          ctrl_i,
  output logic                          stall_o,
  input  logic [OPERAND_WIDTH:0]        quo_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [OPERAND_WIDTH:0] quotient_o
);
  import sdiv_pkg::*;

  logic                   valid_q;
  logic [OPERAND_WIDTH:0] quo_d, quo_q;
  logic                   load;

  assign stall_o = valid_q & out_stall_i;
  assign load    = ~stall_o;

  assign quo_d = ctrl_i.negate ? (~quo_i + 1'b1) : quo_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      quo_q <= quo_d;
    end
  end

  assign out_valid_o = valid_q;
  assign quotient_o  = quo_q;

endmodule

[src/signed_restoring_divider_core.sv]
// ----------------------------------------------------------------------------
// Signed restoring divider core
// Signed quotient, truncated toward zero, by a pipeline of restoring steps.
// ----------------------------------------------------------------------------
// One division enters per cycle unless the input stalls. One stage takes
// the operand magnitudes, OPERAND_WIDTH+1 stages each resolve one quotient
// bit by a compare and subtract, and a last stage applies the sign and holds
// the result. Each stage stalls only while it is full and the one after it
// stalls, so empty stages keep taking new transfers while a finished quotient
// waits. A zero divisor gives a zero quotient, and the most negative dividend
// over -1 gives the positive value 2^(OPERAND_WIDTH-1), which the one extra
// quotient bit holds.
module signed_restoring_divider_core #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [OPERAND_WIDTH-1:0] dividend_i,
  input  logic signed [OPERAND_WIDTH-1:0] divisor_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [OPERAND_WIDTH:0] quotient_o
);
  import sdiv_pkg::*;

  localparam int unsigned NumSteps = OPERAND_WIDTH + 1;

  // Index k is the output of stage k: 0 is the operand stage, k > 0 a step.
  sdiv_ctrl_t               ctrl  [NumSteps+1];
  logic [OPERAND_WIDTH-1:0] rem   [NumSteps+1];
  logic [OPERAND_WIDTH-1:0] den   [NumSteps+1];
  logic [OPERAND_WIDTH:0]   quo   [NumSteps+1];
  logic                     stall [NumSteps+2];

  assign quo[0] = '0;

  sdiv_pre #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_pre (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .stall_o    (stall[0]),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .ctrl_o     (ctrl[0]),
    .rem_o      (rem[0]),
    .den_o      (den[0]),
    .stall_i    (stall[1])
  );

  for (genvar k = 0; k < NumSteps; k++) begin : g_step
    sdiv_step #(
      .OPERAND_WIDTH(OPERAND_WIDTH),
      .SHIFT        (OPERAND_WIDTH - k)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[k]),
      .stall_o (stall[k+1]),
      .rem_i   (rem[k]),
      .den_i   (den[k]),
      .quo_i   (quo[k]),
      .ctrl_o  (ctrl[k+1]),
      .rem_o   (rem[k+1]),
      .den_o   (den[k+1]),
      .quo_o   (quo[k+1]),
      .stall_i (stall[k+2])
    );
  end

  sdiv_post #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl[NumSteps]),
    .stall_o     (stall[NumSteps+1]),
    .quo_i       (quo[NumSteps]),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .quotient_o  (quotient_o)
  );

  assign in_stall_o = stall[0];

`ifndef SYNTH
  // After the last step the remainder is below a nonzero divisor.
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl[NumSteps].valid && !ctrl[NumSteps].div_zero) |->
      (rem[NumSteps] < den[NumSteps]))
    else $error("final remainder not below divisor");

  // The top quotient bit of the magnitude never sets for a nonzero divisor.
  a_quo_top_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl[NumSteps].valid && !ctrl[NumSteps].div_zero) |->
      (quo[NumSteps][OPERAND_WIDTH] == 1'b0))
    else $error("quotient magnitude overflow");

  // A zero divisor leaves every quotient bit clear.
  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl[NumSteps].valid && ctrl[NumSteps].div_zero) |->
      (quo[NumSteps] == '0))
    else $error("zero divisor produced a nonzero quotient");

  // The input side stalls only while the operand stage holds an item.
  a_in_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (ctrl[0].valid && stall[1]))
    else $error("input stalled with operand stage free");
`endif

endmodule

[sim/signed_restoring_divider_core_tb.sv]
// ----------------------------------------------------------------------------
// Signed restoring divider core testbench
// Sends signed divisions through the pipelined divider under random idling on
// both sides. Each quotient is checked in order against a bit-exact restoring
// division computed here, and a long receiver hold-off fills the pipeline.
// ----------------------------------------------------------------------------
module signed_restoring_divider_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned OPW          = 16;
  localparam int unsigned LATENCY      = OPW + 3;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES  = 90;

  localparam logic signed [OPW-1:0] MOST_NEG = {1'b1, {(OPW-1){1'b0}}};
  localparam logic signed [OPW-1:0] MOST_POS = {1'b0, {(OPW-1){1'b1}}};

  typedef struct {
    logic signed [OPW-1:0] dividend;
    logic signed [OPW-1:0] divisor;
    logic signed [OPW:0]   quotient;
  } division_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic signed [OPW-1:0] dividend_i;
  logic signed [OPW-1:0] divisor_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic signed [OPW:0]   quotient_o;

  division_t   pending_quotients[$];
  int unsigned divisions_sent     = 0;
  int unsigned quotients_checked  = 0;
  int unsigned mismatch_count     = 0;
  int unsigned zero_divisor_count = 0;
  int unsigned most_neg_count     = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned idle_cycles        = 0;
  bit          stall_runs_on      = 1'b0;
  bit          hold_off_req       = 1'b0;

  signed_restoring_divider_core #(
    .OPERAND_WIDTH(OPW)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .quotient_o (quotient_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Quotient truncated toward zero, found by restoring steps on the operand
  // magnitudes. Magnitudes are one bit wider so the most negative value fits.
  function automatic logic signed [OPW:0] predict_quotient(
    input logic signed [OPW-1:0] dividend,
    input logic signed [OPW-1:0] divisor
  );
    logic [OPW:0]     mag_dividend;
    logic [OPW:0]     mag_divisor;
    logic [2*OPW+1:0] partial;
    logic [2*OPW+1:0] den_wide;
    logic [OPW:0]     quot;
    int               step;
    mag_dividend = dividend[OPW-1] ? (({{OPW{1'b0}}, 1'b1} << OPW) - {1'b0, dividend})
                                   : {1'b0, dividend};
    mag_divisor  = divisor[OPW-1] ? (({{OPW{1'b0}}, 1'b1} << OPW) - {1'b0, divisor})
                                  : {1'b0, divisor};
    quot = '0;
    if (mag_divisor != '0) begin
      partial  = {{(OPW+1){1'b0}}, mag_dividend};
      den_wide = {{(OPW+1){1'b0}}, mag_divisor};
      for (step = OPW; step >= 0; step--) begin
        quot = quot << 1;
        if ((partial >> step) >= den_wide) begin
          partial = partial - (den_wide << step);
          quot[0] = 1'b1;
        end
      end
    end
    if (dividend[OPW-1] != divisor[OPW-1]) begin
      quot = -quot;
    end
    return quot;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 45) return 0;
    if (pick < 85) return $urandom_range(3, 1);
    if (pick < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Full-range values mixed with small ones, the extremes and powers of two.
  function automatic logic signed [OPW-1:0] random_operand();
    int unsigned           pick;
    logic signed [OPW-1:0] val;
    pick = $urandom_range(99);
    if (pick < 55) begin
      val = OPW'($urandom);
    end else if (pick < 72) begin
      val = OPW'($signed($urandom_range(16)) - 8);
    end else if (pick < 85) begin
      case ($urandom_range(4))
        0:       val = MOST_NEG;
        1:       val = MOST_POS;
        2:       val = -1;
        3:       val = 0;
        default: val = 1;
      endcase
    end else begin
      val = OPW'(1) << $urandom_range(OPW - 1);
      if ($urandom_range(1) == 1) begin
        val = -val;
      end
    end
    return val;
  endfunction

  // Starts at a rising edge or time zero and returns at the rising edge of the
  // transfer with valid still high, so the next call drives at the falling edge.
  task automatic send_division(
    input logic signed [OPW-1:0] dividend,
    input logic signed [OPW-1:0] divisor,
    input int unsigned           gap
  );
    division_t entry;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    dividend_i <= dividend;
    divisor_i  <= divisor;
    do @(posedge clk_i); while (in_stall_o);
    entry.dividend = dividend;
    entry.divisor  = divisor;
    entry.quotient = predict_quotient(dividend, divisor);
    pending_quotients.push_back(entry);
    divisions_sent++;
    if (divisor == 0) zero_divisor_count++;
    if (dividend == MOST_NEG || divisor == MOST_NEG) most_neg_count++;
  endtask

  task automatic wait_for_quotients();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_quotients.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    send_division(MOST_NEG, -1, 0);
    send_division(MOST_NEG, 1, 0);
    send_division(MOST_NEG, MOST_NEG, 0);
    send_division(MOST_POS, MOST_NEG, 0);
    send_division(-1, MOST_NEG, 1);
    send_division(MOST_NEG, MOST_POS, 0);
    send_division(MOST_POS, MOST_POS, 0);
    send_division(MOST_POS, 1, 2);
    send_division(MOST_POS, -1, 0);
    send_division(0, 0, 0);
    send_division(5, 0, 0);
    send_division(MOST_NEG, 0, 3);
    send_division(MOST_POS, 0, 0);
    send_division(0, -5, 0);
    send_division(7, 2, 0);
    send_division(-7, 2, 1);
    send_division(7, -2, 0);
    send_division(-7, -2, 0);
    send_division(1, MOST_POS, 0);
    send_division(100, 7, 0);
    send_division(-16'sd21846, 16'sd3, 0);
    send_division(16'sd21845, -16'sd21846, 0);
  endtask

  task automatic test_random_operands(input int unsigned count);
    stall_runs_on = 1'b1;
    repeat (count) send_division(random_operand(), random_operand(), pick_gap());
  endtask

  // No idling on either side: one transfer per cycle in and out.
  task automatic test_back_to_back(input int unsigned count);
    stall_runs_on = 1'b0;
    repeat (count) send_division(random_operand(), random_operand(), 0);
  endtask

  // The receiver holds off while items keep coming, so the pipeline fills and
  // the block has to stall its input.
  task automatic test_receiver_hold_off(input int unsigned count);
    wait_for_quotients();
    stall_runs_on = 1'b0;
    hold_off_req  = 1'b1;
    repeat (count) send_division(random_operand(), random_operand(), 0);
    stall_runs_on = 1'b1;
  endtask

  // Receiver: random stall runs, or one long hold-off when asked for.
  initial begin : receiver
    int unsigned run_left;
    run_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        if (stall_runs_on && run_left == 0 && $urandom_range(99) < 30) begin
          run_left = pick_gap() + 1;
        end
        if (run_left > 0) begin
          run_left--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_quotients
    division_t entry;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_quotients.size() == 0) begin
        $error("quotient %0d arrived with no division outstanding", quotient_o);
        mismatch_count++;
      end else begin
        entry = pending_quotients.pop_front();
        quotients_checked++;
        if (quotient_o !== entry.quotient) begin
          $error("quotient of %0d / %0d: expected %0d, actual %0d",
                 entry.dividend, entry.divisor, entry.quotient, quotient_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (in_valid_i && in_stall_o) input_stall_cycles++;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("signed_restoring_divider_core_tb NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    dividend_i <= '0;
    divisor_i  <= '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_random_operands(600);
    test_back_to_back(300);
    test_receiver_hold_off(120);
    test_random_operands(300);

    wait_for_quotients();
    repeat (LATENCY + 10) @(posedge clk_i);

    $display("Covered %0d divisions, %0d quotients checked: %0d by zero, %0d with a most",
             divisions_sent, quotients_checked, zero_divisor_count, most_neg_count);
    $display("negative operand; the input was held off for %0d cycles.", input_stall_cycles);
    if (mismatch_count == 0 && pending_quotients.size() == 0) begin
      $display("signed_restoring_divider_core_tb OK");
    end else begin
      $display("signed_restoring_divider_core_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
src/sdiv_pkg.sv
src/sdiv_pre.sv
src/sdiv_step.sv
src/sdiv_post.sv
src/signed_restoring_divider_core.sv
sim/signed_restoring_divider_core_tb.sv
